@@ rtl/core/pm_sensor_frame_parser_defines.svh @@
// Assertion macros shared by the frame parser checker.
// No dependencies; include by bare file name.
`ifndef PM_SENSOR_FRAME_PARSER_DEFINES_SVH
`define PM_SENSOR_FRAME_PARSER_DEFINES_SVH

// Concurrent assertion that is off while reset is high.
`define PMSFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion that also holds across reset.
`define PMSFP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/pmsfp_pkg.sv @@
// Types and constants for the particulate sensor frame parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pmsfp_pkg;

  localparam int FRAME_BYTES = 24;
  localparam int POS_W       = 5;

  localparam logic [7:0] START_A  = 8'h42;
  localparam logic [7:0] START_B  = 8'h4d;
  localparam logic [7:0] LEN_MARK = 8'h14;

  localparam logic [POS_W-1:0] POS_HUNT   = POS_W'(0);
  localparam logic [POS_W-1:0] POS_START2 = POS_W'(1);
  localparam logic [POS_W-1:0] POS_MARKER = POS_W'(3);
  localparam logic [POS_W-1:0] SUM_END    = POS_W'(22);
  localparam logic [POS_W-1:0] LAST_POS   = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] STD_OFF    = POS_W'(4);
  localparam logic [POS_W-1:0] ATM_OFF    = POS_W'(10);

  localparam int GROUP_BYTES = 6;

  // APB register map
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_USE_STD = 1'b0;

  typedef enum logic [1:0] {
    ST_GOOD       = 2'd0,
    ST_CSUM_ERR   = 2'd1,
    ST_MARKER_ERR = 2'd2
  } frame_status_t;

  typedef struct packed {
    logic [15:0]   pm1;
    logic [15:0]   pm2_5;
    logic [15:0]   pm10;
    frame_status_t status;
  } pmsfp_result_t;

endpackage

@@ rtl/core/pm_sensor_frame_parser.sv @@
// Top level of the particulate sensor frame parser.
// Depends on pmsfp_pkg, pmsfp_regs and pmsfp_frame.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+---------------------------------------
//   byte in  | byte_valid / byte_stall  | rx_byte, line_gap
//   result   | result_valid/result_stall| pm1_value, pm2_5_value, pm10_value,
//            |                          | frame_status
//   config   | APB psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
// Takes one byte every cycle unless byte_stall is high. A byte lands in the
// input register, then the frame logic updates its state and, on the last
// frame byte, loads the result register, from which the result is shown.
// Reset (synchronous, high) empties both registers and restarts the hunt.
// A result held by result_stall stalls the byte side whenever a byte sits
// in the input register, whether or not that byte finishes a frame.
`timescale 1ns / 1ps

module pm_sensor_frame_parser
  import pmsfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // byte channel
  input  logic                  byte_valid,
  output logic                  byte_stall,
  input  logic [7:0]            rx_byte,
  input  logic                  line_gap,
  // result channel
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [15:0]           pm1_value,
  output logic [15:0]           pm2_5_value,
  output logic [15:0]           pm10_value,
  output logic [1:0]            frame_status,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic          use_standard_group;
  logic          in_full;
  logic [7:0]    in_byte;
  logic          in_gap;
  logic          advance;
  logic          step;
  logic          emit;
  pmsfp_result_t frame_result;
  pmsfp_result_t out_q;

  pmsfp_regs u_regs (
    .clk                (clk),
    .rst                (rst),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .use_standard_group (use_standard_group)
  );

  // Advance the held byte whenever the result slot is empty or draining.
  assign advance    = !result_valid || !result_stall;
  assign step       = in_full && advance;
  assign byte_stall = in_full && !advance;

  // Input register: load on accept, drop once the byte has been processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      in_byte <= rx_byte;
      in_gap  <= line_gap;
    end
  end

  pmsfp_frame u_frame (
    .clk                (clk),
    .rst                (rst),
    .step               (step),
    .rx_byte            (in_byte),
    .line_gap           (in_gap),
    .use_standard_group (use_standard_group),
    .emit               (emit),
    .result             (frame_result)
  );

  // Result register: load on frame end, hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step && emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_q <= frame_result;
    end
  end

  assign pm1_value    = out_q.pm1;
  assign pm2_5_value  = out_q.pm2_5;
  assign pm10_value   = out_q.pm10;
  assign frame_status = out_q.status;

endmodule

@@ rtl/core/pmsfp_regs.sv @@
// APB configuration register for the frame parser.
// Depends on pmsfp_pkg.
`timescale 1ns / 1ps

module pmsfp_regs
  import pmsfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic                  use_standard_group
);

  logic reg_index;
  logic wr_en;

  assign reg_index = paddr[2];
  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_standard_group <= 1'b0;
    end else if (wr_en && (reg_index == REG_USE_STD)) begin
      use_standard_group <= pwdata[0];
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_USE_STD: prdata = {31'b0, use_standard_group};
      default:     prdata = 32'b0;
    endcase
  end

endmodule

@@ rtl/core/pmsfp_frame.sv @@
// Frame tracking state: hunt, running sum, group capture, marker and checksum check.
// Depends on pmsfp_pkg.
`timescale 1ns / 1ps

module pmsfp_frame
  import pmsfp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    rx_byte,
  input  logic          line_gap,
  input  logic          use_standard_group,
  output logic          emit,
  output pmsfp_result_t result
);

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [15:0]      running_sum, running_sum_next;
  logic [7:0]       captured [GROUP_BYTES];
  logic [7:0]       captured_next [GROUP_BYTES];
  logic [7:0]       checksum_high, checksum_high_next;
  logic             marker_ok, marker_ok_next;
  logic [POS_W-1:0] group_off;
  logic [15:0]      got_sum;

  assign group_off = use_standard_group ? STD_OFF : ATM_OFF;
  assign got_sum   = {checksum_high, rx_byte};

  always_comb begin
    byte_position_next = byte_position;
    running_sum_next   = running_sum;
    checksum_high_next = checksum_high;
    marker_ok_next     = marker_ok;
    captured_next      = captured;
    emit               = 1'b0;
    if (line_gap) begin
      byte_position_next = POS_HUNT;
      running_sum_next   = 16'd0;
    end else if (byte_position == POS_HUNT) begin
      if (rx_byte == START_A) begin
        running_sum_next   = {8'd0, rx_byte};
        byte_position_next = POS_START2;
      end
    end else if (byte_position == POS_START2) begin
      if (rx_byte == START_B) begin
        running_sum_next   = running_sum + {8'd0, rx_byte};
        byte_position_next = byte_position + POS_W'(1);
      end else if (rx_byte == START_A) begin
        running_sum_next   = {8'd0, rx_byte};
      end else begin
        byte_position_next = POS_HUNT;
        running_sum_next   = 16'd0;
      end
    end else begin
      if (byte_position < SUM_END) begin
        running_sum_next = running_sum + {8'd0, rx_byte};
      end
      if (byte_position == POS_MARKER) begin
        marker_ok_next = (rx_byte == LEN_MARK);
      end
      for (int k = 0; k < GROUP_BYTES; k++) begin
        if (byte_position == group_off + POS_W'(k)) begin
          captured_next[k] = rx_byte;
        end
      end
      if (byte_position == SUM_END) begin
        checksum_high_next = rx_byte;
      end
      if (byte_position < LAST_POS) begin
        byte_position_next = byte_position + POS_W'(1);
      end else begin
        emit               = 1'b1;
        byte_position_next = POS_HUNT;
        running_sum_next   = 16'd0;
      end
    end
  end

  always_comb begin
    result.pm1   = {captured[0], captured[1]};
    result.pm2_5 = {captured[2], captured[3]};
    result.pm10  = {captured[4], captured[5]};
    if (!marker_ok) begin
      result.status = ST_MARKER_ERR;
    end else if (got_sum != running_sum) begin
      result.status = ST_CSUM_ERR;
    end else begin
      result.status = ST_GOOD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_HUNT;
      running_sum   <= 16'd0;
      checksum_high <= 8'd0;
      marker_ok     <= 1'b0;
      for (int k = 0; k < GROUP_BYTES; k++) begin
        captured[k] <= 8'd0;
      end
    end else if (step) begin
      byte_position <= byte_position_next;
      running_sum   <= running_sum_next;
      checksum_high <= checksum_high_next;
      marker_ok     <= marker_ok_next;
      captured      <= captured_next;
    end
  end

endmodule

@@ rtl/core/pmsfp_checker.sv @@
// Port-level checker for the frame parser, bound to the top level.
// Depends on pm_sensor_frame_parser_defines.svh and pmsfp_pkg.
`timescale 1ns / 1ps
`include "pm_sensor_frame_parser_defines.svh"

module pmsfp_checker
  import pmsfp_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  byte_stall,
  input logic                  result_valid,
  input logic                  result_stall,
  input logic [15:0]           pm1_value,
  input logic [15:0]           pm2_5_value,
  input logic [15:0]           pm10_value,
  input logic [1:0]            frame_status
);

  `PMSFP_ASSERT_RST(a_reset_clears, rst |=> !result_valid, "result valid right after reset")
  `PMSFP_ASSERT(a_hold, (result_valid && result_stall) |=> (result_valid && $stable(pm1_value) && $stable(pm2_5_value) && $stable(pm10_value) && $stable(frame_status)), "stalled result changed")
  `PMSFP_ASSERT(a_stall_cause, byte_stall |-> (result_valid && result_stall), "byte side stalled without result backpressure")
  `PMSFP_ASSERT(a_status_code, result_valid |-> (frame_status == ST_GOOD || frame_status == ST_CSUM_ERR || frame_status == ST_MARKER_ERR), "undefined frame status")

endmodule

bind pm_sensor_frame_parser pmsfp_checker u_checker (.*);
